/* rtl/battery_runtime_estimator_assert.svh */
// ============================================================================
// battery runtime estimator assertion macros
// shared property macros for the estimator modules, clocked on i_clk and
// disabled while i_rst_n is low
// ============================================================================
`ifndef BATTERY_RUNTIME_ESTIMATOR_ASSERT_SVH
`define BATTERY_RUNTIME_ESTIMATOR_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define BRE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define BRE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BRE_ASSERT_IMP(lbl, ante, cons, msg)
`define BRE_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/bre_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// bre_pkg
// types, codes and constants shared by the runtime estimator modules
// ============================================================================
package bre_pkg;

    // field widths
    localparam int ACT_W      = 2;
    localparam int CUR_W      = 16;
    localparam int CAP_W      = 16;
    localparam int TIME_W     = 32;
    localparam int EST_W      = 3;
    localparam int MIN_W      = 22;
    localparam int CFG_MIN_W  = 15;
    localparam int CFG_FLR_W  = 16;
    localparam int CFG_PCT_W  = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 72;

    // action codes
    localparam logic [ACT_W-1:0] ACT_SAMPLE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LOST   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NONE   = 2'd3;

    // estimate state codes
    localparam logic [EST_W-1:0] EST_UNAVAIL = 3'd0;
    localparam logic [EST_W-1:0] EST_CHARGE  = 3'd1;
    localparam logic [EST_W-1:0] EST_EXTPWR  = 3'd2;
    localparam logic [EST_W-1:0] EST_LOWCUR  = 3'd3;
    localparam logic [EST_W-1:0] EST_STAB    = 3'd4;
    localparam logic [EST_W-1:0] EST_READY   = 3'd5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERCENT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE   = 2'd3;

    // register reset values
    localparam logic [CFG_MIN_W-1:0] RST_MIN_DIS = 15'd20;
    localparam logic [CFG_FLR_W-1:0] RST_FLOOR   = 16'd35;
    localparam logic [CFG_PCT_W-1:0] RST_PERCENT = 7'd30;
    localparam logic [TIME_W-1:0]    RST_SETTLE  = 32'd30000;

    // divide by six as multiply by ceil(2^20/6), exact for numerators below 2^18
    localparam logic [17:0] RECIP6       = 18'd174763;
    localparam int          RECIP6_SHIFT = 20;

    // runtime divider: one quotient bit per cycle
    localparam int DIV_BITS  = MIN_W;
    localparam int DIV_CNT_W = $clog2(DIV_BITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_BLEND,
        ST_FIN,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic eval;
        logic blend;
        logic fin;
        logic div_step;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic skip;
        logic clear;
        logic blend;
        logic div_needed;
        logic div_last;
        logic out_free;
    } t_dp_status;

endpackage

/* rtl/bre_ctrl.sv */
`timescale 1ns / 1ps
// ============================================================================
// bre_ctrl
// sequencer for one item: evaluate, optional blend, finish and divide, deliver
// ============================================================================
`include "battery_runtime_estimator_assert.svh"

module bre_ctrl
    import bre_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_sts,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_EVAL;
                end
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_sts.skip) begin
                    n_state = ST_IDLE;
                end else if (i_sts.clear) begin
                    n_state = ST_DONE;
                end else if (i_sts.blend) begin
                    n_state = ST_BLEND;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_BLEND: begin
                o_cmd.blend = 1'b1;
                n_state     = ST_FIN;
            end
            ST_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = i_sts.div_needed ? ST_DIV : ST_DONE;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `BRE_ASSERT_NXT(a_accept_evals, (r_state == ST_IDLE) && i_in_valid, r_state == ST_EVAL,
        "accepted item not evaluated next")
    `BRE_ASSERT_NXT(a_blend_then_fin, r_state == ST_BLEND, r_state == ST_FIN,
        "blend not followed by finish")
    `BRE_ASSERT_NXT(a_skip_to_idle, (r_state == ST_EVAL) && i_sts.skip, r_state == ST_IDLE,
        "unused action code not dropped")

endmodule

/* rtl/bre_datapath.sv */
`timescale 1ns / 1ps
// ============================================================================
// bre_datapath
// input latch, filter state, threshold logic, runtime divider, output register
// ============================================================================
`include "battery_runtime_estimator_assert.svh"

module bre_datapath
    import bre_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    output t_dp_status              o_sts,
    // input item
    input  logic [ACT_W-1:0]        i_action,
    input  logic signed [CUR_W-1:0] i_avg_current_ma,
    input  logic [CAP_W-1:0]        i_remaining_mah,
    input  logic [TIME_W-1:0]       i_now_ms,
    input  logic                    i_gauge_valid,
    input  logic                    i_is_charging,
    input  logic                    i_ext_power_good,
    // configuration
    input  logic                    i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_wdata,
    // result
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [EST_W-1:0]        o_estimate_state,
    output logic [CUR_W-1:0]        o_filt_ma,
    output logic [MIN_W-1:0]        o_runtime_minutes,
    output logic [TIME_W-1:0]       o_stable_for_ms,
    output logic                    o_resample_request
);

    // configuration
    logic [CFG_MIN_W-1:0] r_min_dis;
    logic [CFG_FLR_W-1:0] r_floor;
    logic [CFG_PCT_W-1:0] r_pct;
    logic [TIME_W-1:0]    r_settle;

    // latched input
    logic [ACT_W-1:0]        r_action;
    logic signed [CUR_W-1:0] r_avg;
    logic [CAP_W-1:0]        r_rem;
    logic [TIME_W-1:0]       r_now;
    logic                    r_valid;
    logic                    r_chg;
    logic                    r_ext;

    // estimator state
    logic              r_filter_ready;
    logic [CUR_W-1:0]  r_filtered;
    logic [TIME_W-1:0] r_stable_since;

    // work registers
    logic [17:0]          r_num;
    logic [MIN_W-1:0]     r_quo;
    logic [CUR_W-1:0]     r_part;
    logic [DIV_CNT_W-1:0] r_cnt;

    // staged result
    logic [EST_W-1:0]  r_res_state;
    logic [CUR_W-1:0]  r_res_dis;
    logic [TIME_W-1:0] r_res_stable;
    logic              r_res_rq;
    logic              r_res_ready;

    // output register
    logic              r_out_valid;
    logic [EST_W-1:0]  r_out_state;
    logic [CUR_W-1:0]  r_out_dis;
    logic [MIN_W-1:0]  r_out_min;
    logic [TIME_W-1:0] r_out_stable;
    logic              r_out_rq;

    logic signed [CUR_W:0] w_avg_ext;
    logic signed [CUR_W:0] w_min_neg;
    logic                  w_low;
    logic [CUR_W:0]        w_neg;
    logic [CUR_W-1:0]      w_d;
    logic [CUR_W-1:0]      w_diff;
    logic [22:0]           w_pct_prod;
    logic [22:0]           w_diff_scaled;
    logic                  w_step;
    logic [17:0]           w_num;
    logic [35:0]           w_blend_prod;
    logic                  w_clear;
    logic [EST_W-1:0]      w_clear_state;
    logic                  w_clear_rq;
    logic [TIME_W-1:0]     w_stable;
    logic                  w_ready;
    logic [MIN_W-1:0]      w_div_num;
    logic [CUR_W:0]        w_trial;
    logic [CUR_W:0]        w_sub;
    logic                  w_ge;

    // low current: avg >= -min_discharge
    assign w_avg_ext = {r_avg[CUR_W-1], r_avg};
    assign w_min_neg = -$signed({2'b00, r_min_dis});
    assign w_low     = (w_avg_ext >= w_min_neg);

    // discharge current, at most 32768
    assign w_neg  = 17'(-w_avg_ext);
    assign w_d    = w_neg[CUR_W-1:0];
    assign w_diff = (w_d > r_filtered) ? (w_d - r_filtered) : (r_filtered - w_d);

    // diff >= floor(prev*pct/100) is the same as 100*(diff+1) > prev*pct
    assign w_pct_prod    = {7'd0, r_filtered} * {16'd0, r_pct};
    assign w_diff_scaled = ({7'd0, w_diff} + 23'd1) * 23'd100;
    assign w_step        = (w_diff >= r_floor) && (w_diff_scaled > w_pct_prod);

    assign w_num        = {r_filtered, 2'b00} + {2'b00, r_filtered} + {2'b00, w_d} + 18'd3;
    assign w_blend_prod = {18'd0, r_num} * {18'd0, RECIP6};

    always_comb begin
        w_clear       = 1'b1;
        w_clear_state = EST_UNAVAIL;
        w_clear_rq    = 1'b0;
        case (r_action)
            ACT_LOAD: begin
                if (r_chg) begin
                    w_clear_state = EST_CHARGE;
                end else if (r_ext) begin
                    w_clear_state = EST_EXTPWR;
                end else if (r_valid) begin
                    w_clear_state = EST_STAB;
                    w_clear_rq    = 1'b1;
                end
            end
            ACT_SAMPLE: begin
                if (!r_valid || (r_rem == '0)) begin
                    w_clear_state = EST_UNAVAIL;
                end else if (r_chg) begin
                    w_clear_state = EST_CHARGE;
                end else if (r_ext) begin
                    w_clear_state = EST_EXTPWR;
                end else if (w_low) begin
                    w_clear_state = EST_LOWCUR;
                end else begin
                    w_clear = 1'b0;
                end
            end
            default: begin
                w_clear_state = EST_UNAVAIL;
            end
        endcase
    end

    assign w_stable  = r_now - r_stable_since;
    assign w_ready   = (w_stable >= r_settle) && (r_filtered != '0);
    assign w_div_num = 22'(r_rem) * 22'd60 + 22'(r_filtered[CUR_W-1:1]);

    // restoring divider step
    assign w_trial = {r_part, r_quo[MIN_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_filtered});
    assign w_sub   = w_trial - {1'b0, r_filtered};

    assign o_sts.skip       = (r_action == ACT_NONE);
    assign o_sts.clear      = w_clear;
    assign o_sts.blend      = r_filter_ready && !w_step;
    assign o_sts.div_needed = w_ready;
    assign o_sts.div_last   = (r_cnt == DIV_CNT_W'(DIV_BITS - 1));
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dis <= RST_MIN_DIS;
            r_floor   <= RST_FLOOR;
            r_pct     <= RST_PERCENT;
            r_settle  <= RST_SETTLE;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_MIN_DIS: r_min_dis <= i_cfg_wdata[CFG_MIN_W-1:0];
                REG_FLOOR:   r_floor   <= i_cfg_wdata[CFG_FLR_W-1:0];
                REG_PERCENT: r_pct     <= i_cfg_wdata[CFG_PCT_W-1:0];
                REG_SETTLE:  r_settle  <= i_cfg_wdata[TIME_W-1:0];
                default:     r_settle  <= r_settle;
            endcase
        end
    end

    // estimator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_ready <= 1'b0;
            r_filtered     <= '0;
            r_stable_since <= '0;
        end else if (i_cmd.eval && (r_action != ACT_NONE)) begin
            if (w_clear) begin
                r_filter_ready <= 1'b0;
                r_filtered     <= '0;
                r_stable_since <= r_now;
            end else if (!r_filter_ready || w_step) begin
                r_filter_ready <= 1'b1;
                r_filtered     <= w_d;
                r_stable_since <= r_now;
            end
        end else if (i_cmd.blend) begin
            r_filtered <= w_blend_prod[RECIP6_SHIFT +: CUR_W];
        end
    end

    // input latch, work and staging registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_action <= i_action;
            r_avg    <= i_avg_current_ma;
            r_rem    <= i_remaining_mah;
            r_now    <= i_now_ms;
            r_valid  <= i_gauge_valid;
            r_chg    <= i_is_charging;
            r_ext    <= i_ext_power_good;
        end
        if (i_cmd.eval) begin
            r_num        <= w_num;
            r_res_state  <= w_clear_state;
            r_res_dis    <= '0;
            r_res_stable <= '0;
            r_res_rq     <= w_clear_rq;
            r_res_ready  <= 1'b0;
        end
        if (i_cmd.fin) begin
            r_res_state  <= w_ready ? EST_READY : EST_STAB;
            r_res_dis    <= r_filtered;
            r_res_stable <= w_stable;
            r_res_rq     <= 1'b0;
            r_res_ready  <= w_ready;
            r_quo        <= w_div_num;
            r_part       <= '0;
            r_cnt        <= '0;
        end
        if (i_cmd.div_step) begin
            r_part <= w_ge ? w_sub[CUR_W-1:0] : w_trial[CUR_W-1:0];
            r_quo  <= {r_quo[MIN_W-2:0], w_ge};
            r_cnt  <= r_cnt + 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_state  <= r_res_state;
            r_out_dis    <= r_res_dis;
            r_out_min    <= r_res_ready ? r_quo : '0;
            r_out_stable <= r_res_stable;
            r_out_rq     <= r_res_rq;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_estimate_state   = r_out_state;
    assign o_filt_ma          = r_out_dis;
    assign o_runtime_minutes  = r_out_min;
    assign o_stable_for_ms    = r_out_stable;
    assign o_resample_request = r_out_rq;

    `BRE_ASSERT_IMP(a_filter_zero_when_cleared, r_filtered != '0, r_filter_ready,
        "nonzero filter while not ready")
    `BRE_ASSERT_IMP(a_filter_range, 1'b1, r_filtered <= 16'd32768,
        "filtered current above full scale")
    `BRE_ASSERT_IMP(a_div_bounded, i_cmd.div_step, r_filtered != '0,
        "divider running on a zero divisor")

endmodule

/* rtl/battery_runtime_estimator.sv */
// path: a clearing item passes evaluate, then the output register; a sample still
//   stabilizing passes evaluate, optional blend and finish; one with runtime also divides
// flow: one item at a time, the next input transfer is taken once the sequencer is
//   back in idle with the result side free; the bit-serial runtime divider sets the
//   worst case, and a new item is taken while the last result waits
// reset: synchronous active-low i_rst_n clears the filter and loads register defaults
`timescale 1ns / 1ps
// ============================================================================
// battery_runtime_estimator
// filters gauge discharge current, detects load steps and reports the
// estimator state and remaining runtime in minutes
// ============================================================================

module battery_runtime_estimator
    import bre_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // avg_current_ma[15:0], remaining_mah[31:16], now_ms[63:32],
    // gauge_valid[64], is_charging[65], ext_power_good[66], zero[71:67]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // action[1:0]
    input  logic [ACT_W-1:0]      s_axis_tuser,
    // results
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // filtered current[15:0], runtime_minutes[37:16], stable_for_ms[69:38],
    // resample_request[70], zero[71]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // estimate_state[2:0]
    output logic [EST_W-1:0]      m_axis_tuser,
    // register writes
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_dp_cmd    w_cmd;
    t_dp_status w_sts;

    logic [CUR_W-1:0]  w_dis;
    logic [MIN_W-1:0]  w_min;
    logic [TIME_W-1:0] w_stable;
    logic              w_rq;

    // sequencer: takes a transfer only when idle
    bre_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // unpack input fields straight into the datapath latch
    bre_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_action           (s_axis_tuser),
        .i_avg_current_ma   (s_axis_tdata[15:0]),
        .i_remaining_mah    (s_axis_tdata[31:16]),
        .i_now_ms           (s_axis_tdata[63:32]),
        .i_gauge_valid      (s_axis_tdata[64]),
        .i_is_charging      (s_axis_tdata[65]),
        .i_ext_power_good   (s_axis_tdata[66]),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .o_out_valid        (m_axis_tvalid),
        .i_out_ready        (m_axis_tready),
        .o_estimate_state   (m_axis_tuser),
        .o_filt_ma          (w_dis),
        .o_runtime_minutes  (w_min),
        .o_stable_for_ms    (w_stable),
        .o_resample_request (w_rq)
    );

    // pack result fields, lowest field first, padded to a whole byte
    assign m_axis_tdata = {1'b0, w_rq, w_stable, w_min, w_dis};

endmodule
